>>> src/sss_pkg.sv
// Shared types and constants for the selective state scan block.
`timescale 1ns / 1ps
package sss_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam int DATA_W  = 32;
  localparam int ACC_W   = 48;
  localparam int PROD_W  = 52;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;

  localparam logic [CNT_W-1:0] REG_DIM_RESET = 7'd16;

  // Register address index.
  localparam logic [0:0] REG_DIM_IN_USE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD_A,
    ST_PROD_DB,
    ST_PROD_TB,
    ST_FIN_MUL,
    ST_FIN_ADD,
    ST_EMIT
  } state_t;

  // Signed saturation of a wide value into ACC_W bits.
  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [PROD_W+1:0] v);
    logic signed [PROD_W+1:0] hi;
    logic signed [PROD_W+1:0] lo;
    hi = (PROD_W+2)'((64'sd1 <<< (ACC_W-1)) - 64'sd1);
    lo = -hi - 1;
    if (v > hi) sat48 = {1'b0, {(ACC_W-1){1'b1}}};
    else if (v < lo) sat48 = {1'b1, {(ACC_W-1){1'b0}}};
    else sat48 = v[ACC_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W+1:0] v);
    if (v > $signed((PROD_W+2)'(64'sh7FFF_FFFF))) sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    else if (v < -$signed((PROD_W+2)'(64'sh8000_0000))) sat32 = {1'b1, {(DATA_W-1){1'b0}}};
    else sat32 = v[DATA_W-1:0];
  endfunction

endpackage

>>> src/sss_mul.sv
// Shared signed fixed-point multiplier: two 32x24 partial products, rounding and clamp.
`timescale 1ns / 1ps
module sss_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             start,
  input  logic signed [sss_pkg::DATA_W-1:0] a,
  input  logic signed [sss_pkg::ACC_W-1:0]  b,
  output logic                             done,
  output logic signed [sss_pkg::PROD_W-1:0] p
);
  import sss_pkg::*;

  localparam logic [63:0] LIM = 64'd1 << 50;

  logic        [31:0] ua;
  logic        [47:0] ub;
  logic               neg;
  logic        [63:0] plo;
  logic        [63:0] phi;
  logic        [63:0] r;
  logic               stg1;
  logic               stg2;
  logic        [63:0] rc;

  // Stage 1: register magnitudes; stage 2: two partial products; stage 3: combine.
  always_ff @(posedge clk) begin
    ua   <= a[DATA_W-1] ? 32'(-a) : 32'(a);
    ub   <= b[ACC_W-1] ? 48'(-b) : 48'(b);
    neg  <= a[DATA_W-1] ^ b[ACC_W-1];
    stg1 <= start;
    plo  <= 64'(ua) * 64'(ub[23:0]);
    phi  <= 64'(ua) * 64'(ub[47:24]);
    stg2 <= stg1;
    done <= stg2;
  end

  always_comb begin
    if (phi >= (64'd1 << (26 + FRAC_BITS))) r = LIM;
    else r = (phi << (24 - FRAC_BITS)) + ((plo + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    rc = (r > LIM) ? LIM : r;
  end

  always_ff @(posedge clk) begin
    if (stg2) p <= neg ? -$signed(PROD_W'(rc)) : $signed(PROD_W'(rc));
  end

endmodule

>>> src/selective_state_scan.sv
// Top level of the selective state scan: tables, state, sequencer, register port.
//
//  channel   dir  handshake        payload
//  in        in   valid / stall    mode row col coeff_value sample_value step_size
//                                  start_of_sequence
//  out       out  out_valid / out_stall  state_value state_index last_of_run
//  apb       in   psel penable pwrite  paddr pwdata prdata
//
// A coefficient load leaves the block ready for the next request. A data item runs a shared
// multiplier over every active state: three products a state, the first of which waits for
// the table read. The closing element adds, for each state, one product, one add and the
// hand-off of its result. Reset clears state, accumulators and the sequencer at once;
// tables stay unwritten. While a result waits under stall the sequencer holds.
`timescale 1ns / 1ps
module selective_state_scan #(
  parameter int DIM       = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [1:0]  mode,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic signed [31:0] coeff_value,
  input  logic signed [31:0] sample_value,
  input  logic signed [31:0] step_size,
  input  logic        start_of_sequence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] state_value,
  output logic [5:0]  state_index,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sss_pkg::*;

  localparam int SW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int TW = (DIM*DIM > 1) ? $clog2(DIM*DIM) : 1;
  localparam logic [CNT_W-1:0] DIM_C = CNT_W'(DIM);

  // Configuration.
  logic [CNT_W-1:0] dim_in_use;
  logic [CNT_W-1:0] k_eff;
  assign pready = 1'b1;
  assign prdata = {25'd0, dim_in_use};

  always_ff @(posedge clk) begin
    if (rst) dim_in_use <= REG_DIM_RESET;
    else if (psel && penable && pwrite && paddr[1:1] == 1'(REG_DIM_IN_USE) && pready)
      dim_in_use <= pwdata[CNT_W-1:0];
  end

  always_comb begin
    if (dim_in_use == '0) k_eff = CNT_W'(1);
    else if (dim_in_use > DIM_C) k_eff = DIM_C;
    else k_eff = dim_in_use;
  end

  // Coefficient memories.
  logic signed [DATA_W-1:0] a_mem [DIM*DIM];
  logic signed [DATA_W-1:0] b_mem [DIM*DIM];
  logic signed [DATA_W-1:0] a_rd;
  logic signed [DATA_W-1:0] b_rd;
  logic [TW-1:0] rd_addr;

  // Per-state registers (each read at the sequencer's index).
  logic signed [DATA_W-1:0] hid [DIM];
  logic signed [ACC_W-1:0]  acc_a [DIM];
  logic signed [ACC_W-1:0]  acc_b [DIM];

  state_t state, state_next;
  logic [SW-1:0] idx;
  logic [5:0]    d_reg;
  logic signed [DATA_W-1:0] x_reg, delta_reg;
  logic closing;
  logic signed [PROD_W-1:0] ta_reg;
  logic signed [DATA_W-1:0] db_reg;
  logic signed [PROD_W-1:0] hm_reg;

  logic mul_start, mul_done;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [ACC_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic issued;
  logic fetched;

  sss_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .start(mul_start), .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  logic accept;
  logic load_ok;
  logic data_ok;
  logic last_idx;
  assign stall  = (state != ST_IDLE);
  assign accept = valid && !stall;
  assign load_ok = (CNT_W'(row) < DIM_C) && (CNT_W'(col) < DIM_C);
  assign data_ok = (mode == MODE_DATA) && (CNT_W'(row) < k_eff);
  assign last_idx = (CNT_W'(idx) == k_eff - CNT_W'(1));

  // Write tables; read the entry for the current state.
  always_ff @(posedge clk) begin
    if (accept && load_ok && mode == MODE_LOAD_A)
      a_mem[TW'(row) * TW'(DIM) + TW'(col)] <= coeff_value;
    if (accept && load_ok && mode == MODE_LOAD_B)
      b_mem[TW'(row) * TW'(DIM) + TW'(col)] <= coeff_value;
    a_rd <= a_mem[rd_addr];
    b_rd <= b_mem[rd_addr];
  end
  assign rd_addr = TW'(d_reg) * TW'(DIM) + TW'(idx);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = delta_reg;
    mul_b = ACC_W'(a_rd);
    case (state)
      ST_PROD_A:  begin mul_a = delta_reg; mul_b = ACC_W'(a_rd); end
      ST_PROD_DB: begin mul_a = delta_reg; mul_b = ACC_W'(b_rd); end
      ST_PROD_TB: begin mul_a = db_reg;    mul_b = ACC_W'(x_reg); end
      ST_FIN_MUL: begin mul_a = hid[idx];  mul_b = acc_a[idx];    end
      default:    begin mul_a = delta_reg; mul_b = ACC_W'(a_rd); end
    endcase
  end

  // Hold the first product of a state until the table read for its index has landed.
  assign mul_start = !issued && ((state == ST_PROD_A && fetched) || state == ST_PROD_DB ||
                                 state == ST_PROD_TB || state == ST_FIN_MUL);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept && data_ok) state_next = ST_PROD_A;
      ST_PROD_A:  if (mul_done) state_next = ST_PROD_DB;
      ST_PROD_DB: if (mul_done) state_next = ST_PROD_TB;
      ST_PROD_TB: if (mul_done) begin
        if (!last_idx) state_next = ST_PROD_A;
        else if (closing) state_next = ST_FIN_MUL;
        else state_next = ST_IDLE;
      end
      ST_FIN_MUL: if (mul_done) state_next = ST_FIN_ADD;
      ST_FIN_ADD: state_next = ST_EMIT;
      ST_EMIT:    if (!out_stall) state_next = last_idx ? ST_IDLE : ST_FIN_MUL;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath and per-state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      issued  <= 1'b0;
      fetched <= 1'b0;
      idx     <= '0;
      for (int i = 0; i < DIM; i++) begin
        hid[i]   <= '0;
        acc_a[i] <= '0;
        acc_b[i] <= '0;
      end
    end else begin
      if (mul_start) issued <= 1'b1;
      if (mul_done)  issued <= 1'b0;
      fetched <= (state == ST_PROD_A) && !mul_done;
      case (state)
        ST_IDLE: if (accept && data_ok) begin
          d_reg     <= row;
          x_reg     <= sample_value;
          delta_reg <= step_size;
          closing   <= (CNT_W'(row) == k_eff - CNT_W'(1));
          idx       <= '0;
          if (start_of_sequence) begin
            for (int i = 0; i < DIM; i++) begin
              hid[i]   <= '0;
              acc_a[i] <= '0;
              acc_b[i] <= '0;
            end
          end
        end
        ST_PROD_A:  if (mul_done) ta_reg <= mul_p;
        ST_PROD_DB: if (mul_done) db_reg <= sat32((PROD_W+2)'(mul_p));
        ST_PROD_TB: if (mul_done) begin
          // Accumulate both terms for this state and advance.
          acc_a[idx] <= sat48((PROD_W+2)'(acc_a[idx]) + (PROD_W+2)'(ta_reg));
          acc_b[idx] <= sat48((PROD_W+2)'(acc_b[idx]) + (PROD_W+2)'(mul_p));
          idx <= last_idx ? '0 : idx + SW'(1);
        end
        ST_FIN_MUL: if (mul_done) hm_reg <= mul_p;
        ST_FIN_ADD: begin
          hid[idx] <= sat32((PROD_W+2)'(hid[idx]) + (PROD_W+2)'(hm_reg)
                            + (PROD_W+2)'(acc_b[idx]));
        end
        ST_EMIT: if (!out_stall) begin
          acc_a[idx] <= '0;
          acc_b[idx] <= '0;
          idx <= last_idx ? '0 : idx + SW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid   = (state == ST_EMIT);
  assign state_value = hid[idx];
  assign state_index = 6'(idx);
  assign last_of_run = last_idx;

  // The sequencer never emits past the active count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CNT_W'(state_index) < k_eff))
    else $error("emitted state beyond active count");

  // A stalled result holds its index.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(state_index)))
    else $error("result moved under stall");

  // The multiplier is only started while a product phase is active.
  assert property (@(posedge clk) disable iff (rst)
    mul_start |-> (state != ST_IDLE && state != ST_EMIT))
    else $error("multiplier started outside a product phase");

endmodule

>>> tb/sv/tb_selective_state_scan.sv
// Self-checking testbench for the selective state scan block.
`timescale 1ns / 1ps
module tb_selective_state_scan;
  import sss_pkg::*;

  localparam int N_ST      = 16;
  localparam int FRAC      = 16;
  localparam int IDLE_WAIT = 600;    // settling time after the last queued state is back
  localparam int WD_LIMIT  = 20000;  // cycles with no request or result accepted

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         index;
    logic               last;
  } state_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic stall;
  logic [1:0] mode = MODE_NONE;
  logic [5:0] row = '0;
  logic [5:0] col = '0;
  logic signed [31:0] coeff_value = '0;
  logic signed [31:0] sample_value = '0;
  logic signed [31:0] step_size = '0;
  logic start_of_sequence = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] state_value;
  logic [5:0] state_index;
  logic last_of_run;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  selective_state_scan dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the block: tables, hidden state, accumulators, dim register.
  logic signed [31:0] decay_coef [N_ST][N_ST];
  logic signed [31:0] input_coef [N_ST][N_ST];
  longint             h_state [N_ST];
  longint             decay_sum [N_ST];
  longint             input_sum [N_ST];
  logic [6:0]         dim_reg = REG_DIM_RESET;

  state_word_t states_due[$];
  int  n_errors = 0;
  int  burst_left = 0;
  int  quiet_cycles = 0;

  function automatic longint clamp_bits(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Exact product, rounded half away from zero, magnitude capped at 2^50.
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] ma, mb, r;
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    r  = (ma * mb + (128'(1) << (FRAC - 1))) >> FRAC;
    if (r > (128'(1) << 50)) r = 128'(1) << 50;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic int active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > N_ST) return N_ST;
    return dim_reg;
  endfunction

  // Advance the shadow model by one accepted request; queue any states it emits.
  function automatic void scan_update(logic [1:0] m, logic [5:0] d, logic [5:0] n,
                                      logic signed [31:0] cv, logic signed [31:0] x,
                                      logic signed [31:0] dt, logic sos);
    int k;
    longint ta, db, tb, t;
    state_word_t w;
    k = active_dim();
    if (m == MODE_LOAD_A || m == MODE_LOAD_B) begin
      if (d < N_ST && n < N_ST) begin
        if (m == MODE_LOAD_A) decay_coef[d][n] = cv;
        else input_coef[d][n] = cv;
      end
      return;
    end
    if (m != MODE_DATA || d >= k) return;
    if (sos) begin
      for (int i = 0; i < N_ST; i++) begin
        h_state[i] = 0; decay_sum[i] = 0; input_sum[i] = 0;
      end
    end
    for (int i = 0; i < k; i++) begin
      ta = fx_mul(dt, decay_coef[d][i]);
      db = clamp_bits(fx_mul(dt, input_coef[d][i]), 32);
      tb = fx_mul(db, x);
      decay_sum[i] = clamp_bits(decay_sum[i] + ta, 48);
      input_sum[i] = clamp_bits(input_sum[i] + tb, 48);
    end
    if (d != k - 1) return;
    for (int i = 0; i < k; i++) begin
      t = h_state[i] + fx_mul(h_state[i], decay_sum[i]) + input_sum[i];
      h_state[i] = clamp_bits(t, 32);
      w.value = h_state[i][31:0];
      w.index = i[5:0];
      w.last  = (i == k - 1);
      states_due.push_back(w);
      decay_sum[i] = 0; input_sum[i] = 0;
    end
  endfunction

  // Drive one request; the sender runs in bursts with random gaps between them.
  task automatic send_req(logic [1:0] m, logic [5:0] d, logic [5:0] n,
                          logic [31:0] cv, logic [31:0] x, logic [31:0] dt, logic sos);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
    valid <= 1'b1;
    mode <= m; row <= d; col <= n;
    coeff_value <= cv; sample_value <= x; step_size <= dt;
    start_of_sequence <= sos;
    @(posedge clk);
    while (stall) @(posedge clk);
    scan_update(m, d, n, cv, x, dt, sos);
    burst_left--;
  endtask

  // Drop valid and hold until every queued state is back, then let the block settle.
  task automatic drain_and_settle();
    valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (states_due.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic reg_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1; pwrite <= wr; penable <= 1'b0;
    paddr <= 2'(REG_DIM_IN_USE * 4); pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Write dim_in_use and read it back.
  task automatic set_dim(logic [6:0] val);
    logic [31:0] rd;
    reg_access(1'b1, 32'(val), rd);
    dim_reg = val;
    reg_access(1'b0, '0, rd);
    if (rd[6:0] !== val) begin
      $display("%0t dim_in_use readback: expected %0d actual %0d", $realtime, val, rd[6:0]);
      n_errors++;
    end
  endtask

  // Mostly modest Q16.16 values so the sums stay meaningful; sometimes any 32-bit word.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return 32'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
    endcase
  endfunction

  // Fill both coefficient tables so no data request ever reads an unwritten entry.
  task automatic test_table_load();
    for (int d = 0; d < N_ST; d++)
      for (int n = 0; n < N_ST; n++) begin
        send_req(MODE_LOAD_A, 6'(d), 6'(n), rand_q(), $urandom, $urandom, $urandom_range(0, 1));
        send_req(MODE_LOAD_B, 6'(d), 6'(n), rand_q(), $urandom, $urandom, $urandom_range(0, 1));
      end
    valid <= 1'b0;
    burst_left = 0;
  endtask

  // Single-element steps with extreme fields, ignored requests and out-of-table loads.
  task automatic test_directed();
    logic [31:0] rd;
    reg_access(1'b0, '0, rd);
    if (rd[6:0] !== REG_DIM_RESET) begin
      $display("%0t dim_in_use after reset: expected %0d actual %0d",
               $realtime, REG_DIM_RESET, rd[6:0]);
      n_errors++;
    end
    set_dim(7'd1);
    send_req(MODE_LOAD_A, 6'd0, 6'd0, 32'h8000_0000, 0, 0, 1'b0);
    send_req(MODE_LOAD_B, 6'd0, 6'd0, 32'h7FFF_FFFF, 0, 0, 1'b0);
    send_req(MODE_DATA, 6'd0, 6'd0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_req(MODE_DATA, 6'd0, 6'd63, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_req(MODE_DATA, 6'd0, 6'd0, 0, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_req(MODE_DATA, 6'd0, 6'd0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_req(MODE_DATA, 6'd0, 6'd0, 0, 0, 0, 1'b1);
    // ignored: unused mode, row beyond active count, loads outside the table
    send_req(MODE_NONE, 6'd0, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_req(MODE_DATA, 6'd63, 6'd0, 0, 32'h0001_0000, 32'h0001_0000, 1'b1);
    send_req(MODE_LOAD_A, 6'd63, 6'd0, 32'h1234_5678, 0, 0, 1'b0);
    send_req(MODE_LOAD_B, 6'd0, 6'd63, 32'h1234_5678, 0, 0, 1'b0);
    send_req(MODE_LOAD_A, 6'd0, 6'd0, 32'h0000_8000, 0, 0, 1'b0);
    send_req(MODE_LOAD_B, 6'd0, 6'd0, 32'h0002_0000, 0, 0, 1'b0);
    send_req(MODE_DATA, 6'd0, 6'd0, 0, 32'h0001_0000, 32'h0000_8000, 1'b0);
    send_req(MODE_DATA, 6'd0, 6'd0, 0, 32'hFFFF_0000, 32'hFFFF_8000, 1'b0);
    drain_and_settle();
  endtask

  // Random steps at one dim setting: well-formed sequences plus noise and broken runs.
  task automatic test_random_steps(logic [6:0] dim_val, int n_req);
    int k, sent;
    set_dim(dim_val);
    k = active_dim();
    sent = 0;
    while (sent < n_req) begin
      if ($urandom_range(0, 9) < 8) begin
        for (int d = 0; d < k; d++) begin
          send_req(MODE_DATA, 6'(d), 6'($urandom), $urandom, rand_q(), rand_q(),
                   (d == 0) ? ($urandom_range(0, 6) == 0) : ($urandom_range(0, 40) == 0));
          sent++;
        end
      end else begin
        case ($urandom_range(0, 4))
          0: send_req(MODE_NONE, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom, 1'b1);
          1: send_req(2'($urandom_range(0, 1)), 6'($urandom), 6'($urandom), rand_q(),
                      $urandom, $urandom, $urandom_range(0, 1));
          default: begin
            send_req(MODE_DATA, 6'($urandom_range(0, 63)), 6'($urandom), $urandom,
                     rand_q(), rand_q(), $urandom_range(0, 1));
            sent++;
          end
        endcase
      end
      // hold off now and then until every queued state has come back
      if ($urandom_range(0, 15) == 0) begin
        valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (states_due.size() != 0) @(posedge clk);
      end
    end
    drain_and_settle();
  endtask

  // Receiver stall: stretches with none, light and heavy back-pressure.
  initial begin
    int level;
    forever begin
      level = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        case (level)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Compare each accepted state word with the oldest one queued.
  always @(posedge clk) begin
    state_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (states_due.size() == 0) begin
        $display("%0t unexpected state: expected none actual value %h index %0d last %b",
                 $realtime, state_value, state_index, last_of_run);
        n_errors++;
      end else begin
        w = states_due.pop_front();
        if (state_value !== w.value) begin
          $display("%0t state_value: expected %h actual %h", $realtime, w.value, state_value);
          n_errors++;
        end
        if (state_index !== w.index) begin
          $display("%0t state_index: expected %0d actual %0d", $realtime, w.index, state_index);
          n_errors++;
        end
        if (last_of_run !== w.last) begin
          $display("%0t last_of_run: expected %b actual %b", $realtime, w.last, last_of_run);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (valid && !stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < N_ST; i++) begin
      h_state[i] = 0; decay_sum[i] = 0; input_sum[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_random_steps(7'd16, 96);
    test_random_steps(7'd1, 60);
    test_random_steps(7'd64, 80);
    test_random_steps(7'd5, 90);
    test_random_steps(7'd16, 84);
    if (n_errors == 0 && states_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
